FILE: design/constant_power_voltage_setter_macros.svh
// Assertion macros used by the controller, cpvs_ctrl.
`ifndef CONSTANT_POWER_VOLTAGE_SETTER_MACROS_SVH
`define CONSTANT_POWER_VOLTAGE_SETTER_MACROS_SVH

// Same-cycle implication.
`define CPVS_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("cpvs assertion failed");

// Next-cycle implication.
`define CPVS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("cpvs assertion failed");

`endif

FILE: design/cpvs_pkg.sv
`timescale 1ns / 1ps

package cpvs_pkg;

  localparam int VOLT_W      = 16;
  localparam int RES_W       = 16;
  localparam int STEP_W      = 10;
  localparam int FAULT_W     = 2;
  localparam int STATUS_W    = 2;
  localparam int POWER_OUT_W = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int Q_W         = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLTAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_STEP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_STEP  = 2'd3;

  localparam logic [VOLT_W-1:0] MAX_VOLTAGE_RST = 16'd9000;
  localparam logic [STEP_W-1:0] POWER_STEP_RST  = 10'd100;
  localparam logic [STEP_W-1:0] FALL_STEP_RST   = 10'd10;
  localparam logic [STEP_W-1:0] BOOST_STEP_RST  = 10'd100;
  localparam int                POWER_RST       = 10000;

  localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_SHORT = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_OPEN  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_IDLE   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FIRING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SHORT  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OPEN   = 2'd3;

  // Round to 10 mV: q = (root + 5) * 52429 >> 19, exact below 2^18.
  localparam logic [VOLT_W:0]   ROUND_BIAS  = 17'd5;
  localparam logic [VOLT_W:0]   ROUND_RECIP = 17'd52429;
  localparam int                ROUND_SHIFT = 19;
  localparam logic [VOLT_W-1:0] VOLT_SAT    = 16'hFFFF;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FIRE,
    OP_MUL_UP,
    OP_MUL_CUR,
    OP_SQRT,
    OP_ROUND,
    OP_SCALE,
    OP_APPLY_UP,
    OP_DEC,
    OP_APPLY_DOWN,
    OP_TRACK_RES,
    OP_APPLY_TRACK,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic up;
    logic down;
    logic dec_ok;
    logic sqrt_last;
  } dp_status_t;

endpackage

FILE: design/cpvs_tick_if.sv
`timescale 1ns / 1ps

interface cpvs_tick_if;
  import cpvs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 fire_pressed;
  logic                 up_pressed;
  logic                 down_pressed;
  logic [RES_W-1:0]     resistance_mohm;
  logic [FAULT_W-1:0]   fault_code;
  logic [VOLT_W-1:0]    measured_mv;

  modport source (
    output valid, fire_pressed, up_pressed, down_pressed, resistance_mohm, fault_code,
           measured_mv,
    input  ready
  );

  modport sink (
    input  valid, fire_pressed, up_pressed, down_pressed, resistance_mohm, fault_code,
           measured_mv,
    output ready
  );
endinterface

FILE: design/cpvs_result_if.sv
`timescale 1ns / 1ps

interface cpvs_result_if;
  import cpvs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   output_enable;
  logic [VOLT_W-1:0]      voltage_setpoint_mv;
  logic [POWER_OUT_W-1:0] power_setting_mw;
  logic [VOLT_W-1:0]      shown_voltage_mv;
  logic [STATUS_W-1:0]    status;

  modport source (
    output valid, output_enable, voltage_setpoint_mv, power_setting_mw, shown_voltage_mv,
           status,
    input  ready
  );

  modport sink (
    input  valid, output_enable, voltage_setpoint_mv, power_setting_mw, shown_voltage_mv,
           status,
    output ready
  );
endinterface

FILE: design/cpvs_dp.sv
`timescale 1ns / 1ps

module cpvs_dp #(
  parameter int POWER_WIDTH = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [cpvs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpvs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  cpvs_pkg::dp_op_t                   op,
  output cpvs_pkg::dp_status_t               status,
  input  logic                               fire_pressed,
  input  logic                               up_pressed,
  input  logic                               down_pressed,
  input  logic [cpvs_pkg::RES_W-1:0]         resistance_mohm,
  input  logic [cpvs_pkg::FAULT_W-1:0]       fault_code,
  input  logic [cpvs_pkg::VOLT_W-1:0]        measured_mv,
  output logic                               output_enable,
  output logic [cpvs_pkg::VOLT_W-1:0]        voltage_setpoint_mv,
  output logic [cpvs_pkg::POWER_OUT_W-1:0]   power_setting_mw,
  output logic [cpvs_pkg::VOLT_W-1:0]        shown_voltage_mv,
  output logic [cpvs_pkg::STATUS_W-1:0]      status_code
);
  import cpvs_pkg::*;

  localparam int PROD_W   = POWER_WIDTH + RES_W;
  localparam int SQ_PAIRS = (PROD_W + 1) / 2;
  localparam int RAD_W    = 2 * SQ_PAIRS;
  localparam int ROOT_W   = SQ_PAIRS;
  localparam int CNT_W    = $clog2(SQ_PAIRS + 1);
  localparam logic [POWER_WIDTH-1:0] POWER_MAX = '1;

  logic [VOLT_W-1:0]       max_voltage;
  logic [STEP_W-1:0]       power_step;
  logic [STEP_W-1:0]       fall_step;
  logic [STEP_W-1:0]       boost_step;

  logic [POWER_WIDTH-1:0]  power_level;
  logic [VOLT_W-1:0]       setpoint;
  logic                    enable;
  logic [RES_W-1:0]        last_res;
  logic [CNT_W-1:0]        sq_cnt;

  logic                    in_fire;
  logic                    in_up;
  logic                    in_down;
  logic [RES_W-1:0]        in_res;
  logic [FAULT_W-1:0]      in_fault;
  logic [VOLT_W-1:0]       in_measured;
  logic [POWER_WIDTH-1:0]  power_up;
  logic [RAD_W-1:0]        rad;
  logic [ROOT_W+1:0]       rem;
  logic [ROOT_W-1:0]       root;
  logic [Q_W-1:0]          rnd_q;
  logic                    rnd_sat;
  logic [VOLT_W-1:0]       tgt;

  logic [POWER_WIDTH-1:0]  step_ext;
  logic [POWER_WIDTH:0]    up_sum;
  logic [POWER_WIDTH-1:0]  up_sat;
  logic                    dec_ok;
  logic [POWER_WIDTH-1:0]  mul_a;
  logic [PROD_W-1:0]       product;
  logic [ROOT_W+1:0]       rem_sh;
  logic [ROOT_W+1:0]       trial;
  logic                    sq_ge;
  logic [ROOT_W+1:0]       sq_diff;
  logic                    root_sat;
  logic [VOLT_W:0]         rnd_x;
  logic [2*VOLT_W+1:0]     rnd_prod;
  logic [VOLT_W-1:0]       tgt_val;
  logic [VOLT_W-1:0]       down_sp;
  logic [VOLT_W-1:0]       fall_ext;
  logic [VOLT_W:0]         nv;
  logic [VOLT_W-1:0]       track_sp;
  logic [POWER_WIDTH+POWER_OUT_W-1:0] power_ext;
  logic [STATUS_W-1:0]     status_val;

  assign step_ext = {{(POWER_WIDTH-STEP_W){1'b0}}, power_step};
  assign up_sum   = {1'b0, power_level} + {1'b0, step_ext};
  assign up_sat   = up_sum[POWER_WIDTH] ? POWER_MAX : up_sum[POWER_WIDTH-1:0];
  assign dec_ok   = power_level >= step_ext;

  assign mul_a   = (op == OP_MUL_UP) ? power_up : power_level;
  assign product = {{RES_W{1'b0}}, mul_a} * {{POWER_WIDTH{1'b0}}, last_res};

  assign rem_sh  = {rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
  assign trial   = {root, 2'b01};
  assign sq_ge   = rem_sh >= trial;
  assign sq_diff = rem_sh - trial;

  assign root_sat = root >= ROOT_W'(VOLT_SAT);
  assign rnd_x    = {1'b0, root[VOLT_W-1:0]} + ROUND_BIAS;
  assign rnd_prod = {{(VOLT_W+1){1'b0}}, rnd_x} * {{(VOLT_W+1){1'b0}}, ROUND_RECIP};
  assign tgt_val  = {rnd_q, 3'b000} + {2'b00, rnd_q, 1'b0};

  assign down_sp  = (tgt > max_voltage) ? max_voltage : tgt;
  assign fall_ext = {{(VOLT_W-STEP_W){1'b0}}, fall_step};

  always_comb begin
    if (!enable) begin
      nv = {1'b0, tgt};
    end else if (tgt < setpoint) begin
      nv = (setpoint >= fall_ext) ? {1'b0, setpoint - fall_ext} : {1'b0, setpoint};
    end else begin
      nv = {1'b0, setpoint} + {{(VOLT_W+1-STEP_W){1'b0}}, boost_step};
    end
  end

  assign track_sp  = (nv > {1'b0, max_voltage}) ? max_voltage : nv[VOLT_W-1:0];
  assign power_ext = {{POWER_OUT_W{1'b0}}, power_level};

  always_comb begin
    case (in_fault)
      FAULT_SHORT: status_val = STATUS_SHORT;
      FAULT_OPEN:  status_val = STATUS_OPEN;
      default:     status_val = enable ? STATUS_FIRING : STATUS_IDLE;
    endcase
  end

  assign status.up        = in_up;
  assign status.down      = in_down;
  assign status.dec_ok    = dec_ok;
  assign status.sqrt_last = (sq_cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      max_voltage <= MAX_VOLTAGE_RST;
      power_step  <= POWER_STEP_RST;
      fall_step   <= FALL_STEP_RST;
      boost_step  <= BOOST_STEP_RST;
      power_level <= POWER_WIDTH'(POWER_RST);
      setpoint    <= '0;
      enable      <= 1'b0;
      last_res    <= '0;
      sq_cnt      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_VOLTAGE: max_voltage <= cfg_data;
          CFG_POWER_STEP:  power_step  <= cfg_data[STEP_W-1:0];
          CFG_FALL_STEP:   fall_step   <= cfg_data[STEP_W-1:0];
          CFG_BOOST_STEP:  boost_step  <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      case (op)
        OP_FIRE: begin
          if (!enable && in_fire && last_res != '0 && in_fault == FAULT_NONE) begin
            enable <= 1'b1;
          end else if (enable && !in_fire) begin
            enable <= 1'b0;
          end
        end
        OP_MUL_UP, OP_MUL_CUR: sq_cnt <= CNT_W'(SQ_PAIRS);
        OP_SQRT: sq_cnt <= sq_cnt - CNT_W'(1);
        OP_APPLY_UP: begin
          if (tgt <= max_voltage) begin
            power_level <= power_up;
            setpoint    <= tgt;
          end
        end
        OP_DEC:        power_level <= power_level - step_ext;
        OP_APPLY_DOWN: setpoint <= down_sp;
        OP_TRACK_RES:  last_res <= in_res;
        OP_APPLY_TRACK: begin
          if (tgt != setpoint) begin
            setpoint <= track_sp;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        in_fire     <= fire_pressed;
        in_up       <= up_pressed;
        in_down     <= down_pressed;
        in_res      <= resistance_mohm;
        in_fault    <= fault_code;
        in_measured <= measured_mv;
      end
      OP_FIRE: power_up <= up_sat;
      OP_MUL_UP, OP_MUL_CUR: begin
        rad  <= RAD_W'(product);
        rem  <= '0;
        root <= '0;
      end
      OP_SQRT: begin
        rad  <= rad << 2;
        rem  <= sq_ge ? sq_diff : rem_sh;
        root <= {root[ROOT_W-2:0], sq_ge};
      end
      OP_ROUND: begin
        rnd_q   <= rnd_prod[ROUND_SHIFT +: Q_W];
        rnd_sat <= root_sat;
      end
      OP_SCALE: tgt <= rnd_sat ? VOLT_SAT : tgt_val;
      OP_EMIT: begin
        output_enable       <= enable;
        voltage_setpoint_mv <= setpoint;
        power_setting_mw    <= power_ext[POWER_OUT_W-1:0];
        shown_voltage_mv    <= enable ? in_measured : setpoint;
        status_code         <= status_val;
      end
      default: ;
    endcase
  end

endmodule

FILE: design/cpvs_ctrl.sv
`timescale 1ns / 1ps
`include "constant_power_voltage_setter_macros.svh"

module cpvs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick_valid,
  output logic                  tick_ready,
  output logic                  result_valid,
  input  logic                  result_ready,
  output cpvs_pkg::dp_op_t      op,
  input  cpvs_pkg::dp_status_t  status
);
  import cpvs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRE,
    S_UP_MUL,
    S_DN_DEC,
    S_DN_MUL,
    S_TRK_RES,
    S_TRK_MUL,
    S_SQRT,
    S_ROUND,
    S_SCALE,
    S_APPLY,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_UP,
    PH_DN,
    PH_TRK
  } phase_t;

  state_t state;
  state_t state_next;
  phase_t phase;
  phase_t phase_next;

  assign tick_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (tick_valid) begin
          op         = OP_LOAD;
          state_next = S_FIRE;
        end
      end
      S_FIRE: begin
        op = OP_FIRE;
        if (status.up) begin
          state_next = S_UP_MUL;
        end else if (status.down) begin
          state_next = S_DN_DEC;
        end else begin
          state_next = S_TRK_RES;
        end
      end
      S_UP_MUL: begin
        op         = OP_MUL_UP;
        phase_next = PH_UP;
        state_next = S_SQRT;
      end
      S_DN_DEC: begin
        if (status.dec_ok) begin
          op         = OP_DEC;
          state_next = S_DN_MUL;
        end else begin
          state_next = S_TRK_RES;
        end
      end
      S_DN_MUL: begin
        op         = OP_MUL_CUR;
        phase_next = PH_DN;
        state_next = S_SQRT;
      end
      S_TRK_RES: begin
        op         = OP_TRACK_RES;
        state_next = S_TRK_MUL;
      end
      S_TRK_MUL: begin
        op         = OP_MUL_CUR;
        phase_next = PH_TRK;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        op = OP_SQRT;
        if (status.sqrt_last) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        op         = OP_ROUND;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        op         = OP_SCALE;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        case (phase)
          PH_UP: begin
            op         = OP_APPLY_UP;
            state_next = status.down ? S_DN_DEC : S_TRK_RES;
          end
          PH_DN: begin
            op         = OP_APPLY_DOWN;
            state_next = S_TRK_RES;
          end
          default: begin
            op         = OP_APPLY_TRACK;
            state_next = S_EMIT;
          end
        endcase
      end
      S_EMIT: begin
        if (!result_valid || result_ready) begin
          op         = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_TRK;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (op == OP_EMIT) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  `CPVS_ASSERT_NEXT(a_accept_fire, clk, rst, tick_valid && tick_ready, state == S_FIRE)
  `CPVS_ASSERT_NEXT(a_sqrt_round, clk, rst, state == S_SQRT && status.sqrt_last, state == S_ROUND)
  `CPVS_ASSERT_NEXT(a_emit_valid, clk, rst, op == OP_EMIT, result_valid && state == S_IDLE)
  `CPVS_ASSERT_IMPL(a_emit_free, clk, rst, op == OP_EMIT, !result_valid || result_ready)

endmodule

FILE: design/constant_power_voltage_setter.sv
`timescale 1ns / 1ps
// Constant-power voltage setter.
// tick (sink): one control tick per transaction: buttons, resistance reading,
//   fault code and measured voltage; taken when valid and ready are high.
// result (source): one transaction per tick with enable, setpoint, power,
//   shown voltage and status; held in an output register until taken.
// cfg: write port; cfg_index selects max voltage, power step, fall step or
//   boost step, written at any edge with cfg_we high.
// Each tick runs up to three voltage targets sqrt(P*R) through one shared
// multiplier and a bit-pair square root unit of (POWER_WIDTH+17)/2 steps.
// Every tick computes the tracking target; an up press adds a target, and
// a down press adds a decrement and a target unless power is below the step.
// A new tick is accepted the cycle after its result is loaded.
// Reset: registers return to 9000 mV, 100 mW, 10 mV, 100 mV; power 10000 mW,
//   setpoint 0, output off, stored resistance 0.
// When result stalls, a finished tick waits in the last step; the next tick
//   is still accepted while the previous result sits unread.
module constant_power_voltage_setter #(
  parameter int POWER_WIDTH = 20
) (
  input  logic                             clk,
  input  logic                             rst,
  cpvs_tick_if.sink                        tick,
  cpvs_result_if.source                    result,
  input  logic                             cfg_we,
  input  logic [cpvs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpvs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cpvs_pkg::*;

  dp_op_t     op;
  dp_status_t status;
  logic       tick_ready;
  logic       result_valid;

  assign tick.ready   = tick_ready;
  assign result.valid = result_valid;

  cpvs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick.valid),
    .tick_ready   (tick_ready),
    .result_valid (result_valid),
    .result_ready (result.ready),
    .op           (op),
    .status       (status)
  );

  cpvs_dp #(
    .POWER_WIDTH (POWER_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .op                  (op),
    .status              (status),
    .fire_pressed        (tick.fire_pressed),
    .up_pressed          (tick.up_pressed),
    .down_pressed        (tick.down_pressed),
    .resistance_mohm     (tick.resistance_mohm),
    .fault_code          (tick.fault_code),
    .measured_mv         (tick.measured_mv),
    .output_enable       (result.output_enable),
    .voltage_setpoint_mv (result.voltage_setpoint_mv),
    .power_setting_mw    (result.power_setting_mw),
    .shown_voltage_mv    (result.shown_voltage_mv),
    .status_code         (result.status)
  );

endmodule

FILE: verif/cpvs_checker.sv
`timescale 1ns / 1ps

module cpvs_checker #(
  parameter int POWER_WIDTH = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  cpvs_tick_if                            tick,
  cpvs_result_if                          result,
  input  logic                            cfg_we,
  input  logic [cpvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpvs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import cpvs_pkg::*;

  localparam logic [POWER_WIDTH-1:0] POWER_TOP = '1;

  typedef struct packed {
    logic                   enable;
    logic [VOLT_W-1:0]      setpoint;
    logic [POWER_OUT_W-1:0] power;
    logic [VOLT_W-1:0]      shown;
    logic [STATUS_W-1:0]    status;
  } readout_t;

  logic [VOLT_W-1:0]      max_mv;
  logic [STEP_W-1:0]      step_mw;
  logic [STEP_W-1:0]      fall_mv;
  logic [STEP_W-1:0]      boost_mv;

  logic [POWER_WIDTH-1:0] power_lvl;
  logic [VOLT_W-1:0]      setpoint;
  logic                   enabled;
  logic [RES_W-1:0]       stored_res;

  readout_t               expected_readouts[$];
  int                     errs = 0;

  function automatic logic [31:0] int_sqrt(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = x;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[31:0];
  endfunction

  function automatic logic [VOLT_W-1:0] coil_target(input logic [POWER_WIDTH-1:0] p,
                                                    input logic [RES_W-1:0] r);
    logic [63:0] rounded;
    rounded = ((64'(int_sqrt(64'(p) * 64'(r))) + 64'd5) / 64'd10) * 64'd10;
    return (rounded > 64'd65535) ? VOLT_SAT : rounded[VOLT_W-1:0];
  endfunction

  function automatic logic [VOLT_W-1:0] clamp_mv(input logic [VOLT_W:0] v);
    return (v > {1'b0, max_mv}) ? max_mv : v[VOLT_W-1:0];
  endfunction

  function automatic readout_t advance_tick(input logic fire, input logic up, input logic down,
                                            input logic [RES_W-1:0] res,
                                            input logic [FAULT_W-1:0] fault,
                                            input logic [VOLT_W-1:0] measured);
    logic [POWER_WIDTH:0] raised;
    logic [VOLT_W-1:0]    tgt;
    logic [VOLT_W:0]      nv;
    readout_t             ro;
    if (!enabled && fire && stored_res != '0 && fault == FAULT_NONE) enabled = 1'b1;
    else if (enabled && !fire) enabled = 1'b0;

    if (up) begin
      raised = {1'b0, power_lvl} + (POWER_WIDTH+1)'(step_mw);
      if (raised > {1'b0, POWER_TOP}) raised = {1'b0, POWER_TOP};
      tgt = coil_target(raised[POWER_WIDTH-1:0], stored_res);
      if (tgt <= max_mv) begin
        power_lvl = raised[POWER_WIDTH-1:0];
        setpoint  = tgt;
      end
    end
    if (down && power_lvl >= POWER_WIDTH'(step_mw)) begin
      power_lvl = power_lvl - POWER_WIDTH'(step_mw);
      setpoint  = clamp_mv({1'b0, coil_target(power_lvl, stored_res)});
    end

    stored_res = res;
    tgt = coil_target(power_lvl, stored_res);
    if (tgt != setpoint) begin
      nv = {1'b0, tgt};
      if (enabled) begin
        if (tgt < setpoint)
          nv = (setpoint >= VOLT_W'(fall_mv)) ? {1'b0, setpoint - VOLT_W'(fall_mv)}
                                              : {1'b0, setpoint};
        else nv = {1'b0, setpoint} + (VOLT_W+1)'(boost_mv);
      end
      setpoint = clamp_mv(nv);
    end

    ro.enable   = enabled;
    ro.setpoint = setpoint;
    ro.power    = POWER_OUT_W'(power_lvl);
    ro.shown    = enabled ? measured : setpoint;
    case (fault)
      FAULT_SHORT: ro.status = STATUS_SHORT;
      FAULT_OPEN:  ro.status = STATUS_OPEN;
      default:     ro.status = enabled ? STATUS_FIRING : STATUS_IDLE;
    endcase
    return ro;
  endfunction

  always @(posedge clk) begin : watch
    readout_t seen;
    readout_t want;
    if (rst) begin
      max_mv     = MAX_VOLTAGE_RST;
      step_mw    = POWER_STEP_RST;
      fall_mv    = FALL_STEP_RST;
      boost_mv   = BOOST_STEP_RST;
      power_lvl  = POWER_WIDTH'(POWER_RST);
      setpoint   = '0;
      enabled    = 1'b0;
      stored_res = '0;
      expected_readouts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_VOLTAGE: max_mv   = cfg_data;
          CFG_POWER_STEP:  step_mw  = cfg_data[STEP_W-1:0];
          CFG_FALL_STEP:   fall_mv  = cfg_data[STEP_W-1:0];
          CFG_BOOST_STEP:  boost_mv = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end

      if (result.valid && result.ready) begin
        seen.enable   = result.output_enable;
        seen.setpoint = result.voltage_setpoint_mv;
        seen.power    = result.power_setting_mw;
        seen.shown    = result.shown_voltage_mv;
        seen.status   = result.status;
        if (expected_readouts.size() == 0) begin
          if (errs < 10)
            $display("unexpected result transaction: en=%0d sp=%0d pw=%0d shown=%0d st=%0d",
                     seen.enable, seen.setpoint, seen.power, seen.shown, seen.status);
          errs++;
        end else begin
          want = expected_readouts.pop_front();
          if (seen.enable !== want.enable || seen.setpoint !== want.setpoint ||
              seen.power !== want.power || seen.shown !== want.shown ||
              seen.status !== want.status) begin
            if (errs < 10)
              $display({"result mismatch: expected en=%0d sp=%0d pw=%0d shown=%0d st=%0d,",
                        " got en=%0d sp=%0d pw=%0d shown=%0d st=%0d"},
                       want.enable, want.setpoint, want.power, want.shown, want.status,
                       seen.enable, seen.setpoint, seen.power, seen.shown, seen.status);
            errs++;
          end
        end
      end

      if (tick.valid && tick.ready)
        expected_readouts.push_back(advance_tick(tick.fire_pressed, tick.up_pressed,
                                                 tick.down_pressed, tick.resistance_mohm,
                                                 tick.fault_code, tick.measured_mv));
    end
    fail_count <= errs;
    pending    <= expected_readouts.size();
  end

endmodule

FILE: verif/tb_constant_power_voltage_setter.sv
`timescale 1ns / 1ps

module tb_constant_power_voltage_setter;
  import cpvs_pkg::*;

  localparam int                 POWER_WIDTH  = 20;
  localparam int                 HOLD_CYCLES  = 600;
  localparam logic [FAULT_W-1:0] FAULT_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  int   src_idle_pct  = 35;
  int   sink_idle_pct = 35;
  int   hold_req      = 0;
  int   hold_seen     = 0;
  logic fire_held;
  int   res_now;

  cpvs_tick_if   tick_bus ();
  cpvs_result_if result_bus ();

  constant_power_voltage_setter #(
    .POWER_WIDTH(POWER_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick_bus),
    .result   (result_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  cpvs_checker #(
    .POWER_WIDTH(POWER_WIDTH)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_bus),
    .result    (result_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #6 clk = ~clk;

  task automatic send_tick(input logic f, input logic u, input logic d,
                           input logic [RES_W-1:0] r, input logic [FAULT_W-1:0] fc,
                           input logic [VOLT_W-1:0] m);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      tick_bus.valid <= 1'b0;
      @(negedge clk);
    end
    tick_bus.valid           <= 1'b1;
    tick_bus.fire_pressed    <= f;
    tick_bus.up_pressed      <= u;
    tick_bus.down_pressed    <= d;
    tick_bus.resistance_mohm <= r;
    tick_bus.fault_code      <= fc;
    tick_bus.measured_mv     <= m;
    @(posedge clk);
    while (!tick_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_tick(input bit climb);
    int                 pick;
    logic               up;
    logic               down;
    logic [FAULT_W-1:0] fc;
    logic [VOLT_W-1:0]  m;
    if ($urandom_range(99) < 12) fire_held = ~fire_held;
    pick = $urandom_range(99);
    if (pick < 55) begin
    end else if (pick < 80) begin
      res_now = res_now + int'($urandom_range(600)) - 300;
    end else if (pick < 88) begin
      res_now = 0;
    end else if (pick < 93) begin
      res_now = 65535;
    end else begin
      res_now = int'($urandom_range(65535));
    end
    if (res_now < 0) res_now = 0;
    if (res_now > 65535) res_now = 65535;
    if (climb) begin
      up   = ($urandom_range(99) < 97);
      down = ($urandom_range(99) < 2);
    end else begin
      up   = ($urandom_range(99) < 30);
      down = ($urandom_range(99) < 25);
    end
    fc = ($urandom_range(99) < 85) ? FAULT_NONE : FAULT_W'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 10) m = '0;
    else if (pick < 20) m = '1;
    else m = VOLT_W'($urandom_range(65535));
    send_tick(fire_held, up, down, RES_W'(res_now), fc, m);
  endtask

  task automatic program_cfg(input logic [VOLT_W-1:0] max_mv, input logic [STEP_W-1:0] ps,
                             input logic [STEP_W-1:0] fall, input logic [STEP_W-1:0] boost);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_VOLTAGE;
    cfg_data  <= max_mv;
    @(negedge clk);
    cfg_index <= CFG_POWER_STEP;
    cfg_data  <= CFG_DATA_W'(ps);
    @(negedge clk);
    cfg_index <= CFG_FALL_STEP;
    cfg_data  <= CFG_DATA_W'(fall);
    @(negedge clk);
    cfg_index <= CFG_BOOST_STEP;
    cfg_data  <= CFG_DATA_W'(boost);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    tick_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen++;
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      result_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("tb_constant_power_voltage_setter failed");
    $finish;
  end

  initial begin
    rst                      = 1'b1;
    cfg_we                   = 1'b0;
    cfg_index                = CFG_MAX_VOLTAGE;
    cfg_data                 = '0;
    tick_bus.valid           = 1'b0;
    tick_bus.fire_pressed    = 1'b0;
    tick_bus.up_pressed      = 1'b0;
    tick_bus.down_pressed    = 1'b0;
    tick_bus.resistance_mohm = '0;
    tick_bus.fault_code      = FAULT_NONE;
    tick_bus.measured_mv     = '0;
    fire_held                = 1'b0;
    res_now                  = 1500;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fire blocked with no stored coil, then on, drift down and up, faults while on
    send_tick(1'b1, 1'b0, 1'b0, 16'd2000, FAULT_NONE, 16'd0);
    send_tick(1'b1, 1'b0, 1'b0, 16'd2000, FAULT_NONE, 16'hFFFF);
    send_tick(1'b1, 1'b0, 1'b0, 16'd1000, FAULT_NONE, 16'd1234);
    send_tick(1'b1, 1'b0, 1'b0, 16'd3000, FAULT_NONE, 16'd4321);
    send_tick(1'b1, 1'b0, 1'b0, 16'd3000, FAULT_SHORT, 16'd5000);
    send_tick(1'b1, 1'b0, 1'b0, 16'd3000, FAULT_OPEN, 16'd5001);
    send_tick(1'b1, 1'b0, 1'b0, 16'd3000, FAULT_UNUSED, 16'd5002);
    send_tick(1'b0, 1'b0, 1'b0, 16'd3000, FAULT_NONE, 16'd5003);
    send_tick(1'b1, 1'b0, 1'b0, 16'd3000, FAULT_SHORT, 16'd5004);
    send_tick(1'b1, 1'b0, 1'b0, 16'd3000, FAULT_UNUSED, 16'd5005);
    send_tick(1'b0, 1'b1, 1'b0, 16'd3000, FAULT_NONE, 16'd0);
    send_tick(1'b0, 1'b1, 1'b0, 16'hFFFF, FAULT_NONE, 16'd0);
    send_tick(1'b0, 1'b1, 1'b0, 16'hFFFF, FAULT_NONE, 16'd0);
    send_tick(1'b0, 1'b0, 1'b1, 16'hFFFF, FAULT_NONE, 16'd0);
    send_tick(1'b0, 1'b1, 1'b1, 16'd500, FAULT_NONE, 16'd0);
    send_tick(1'b0, 1'b0, 1'b0, 16'd0, FAULT_NONE, 16'hFFFF);
    send_tick(1'b1, 1'b0, 1'b0, 16'hFFFF, FAULT_NONE, 16'hFFFF);
    send_tick(1'b1, 1'b1, 1'b0, 16'hFFFF, FAULT_NONE, 16'd0);
    drain();

    // zero power step, fall step larger than the setpoint
    program_cfg(16'hFFFF, 10'd0, 10'h3FF, 10'h3FF);
    send_tick(1'b0, 1'b0, 1'b0, 16'd1, FAULT_NONE, 16'd7);
    send_tick(1'b1, 1'b0, 1'b0, 16'd1, FAULT_NONE, 16'd7);
    send_tick(1'b1, 1'b0, 1'b0, 16'd0, FAULT_NONE, 16'd7);
    send_tick(1'b1, 1'b1, 1'b0, 16'd0, FAULT_NONE, 16'd7);
    send_tick(1'b1, 1'b0, 1'b1, 16'hFFFF, FAULT_NONE, 16'd7);
    drain();

    // everything clamped to zero volts
    program_cfg(16'd0, 10'h3FF, 10'd0, 10'd0);
    send_tick(1'b1, 1'b1, 1'b0, 16'hFFFF, FAULT_NONE, 16'hFFFF);
    send_tick(1'b0, 1'b0, 1'b1, 16'd300, FAULT_NONE, 16'd0);
    drain();

    program_cfg(MAX_VOLTAGE_RST, POWER_STEP_RST, FALL_STEP_RST, BOOST_STEP_RST);
    hold_req++;
    repeat (100) random_tick(1'b0);
    drain();

    repeat (2) begin
      program_cfg(VOLT_W'($urandom_range(65535)), STEP_W'($urandom_range(1023)),
                  STEP_W'($urandom_range(1023)), STEP_W'($urandom_range(1023)));
      repeat (50) random_tick(1'b0);
      drain();
    end

    // climb to power saturation
    program_cfg(16'hFFFF, 10'h3FF, STEP_W'($urandom_range(1023)),
                STEP_W'($urandom_range(1023)));
    for (int n = 0; n < 1150; n++) begin
      if (n == 200) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (n == 500) begin
        src_idle_pct  = 35;
        sink_idle_pct = 35;
      end
      random_tick(1'b1);
    end
    drain();

    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_constant_power_voltage_setter passed");
    end else begin
      $display("tb_constant_power_voltage_setter failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/cpvs_pkg.sv
design/cpvs_tick_if.sv
design/cpvs_result_if.sv
design/cpvs_dp.sv
design/cpvs_ctrl.sv
design/constant_power_voltage_setter.sv
verif/cpvs_checker.sv
verif/tb_constant_power_voltage_setter.sv
